>>> hdl/fbsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsd_pkg: shared constants and types for the fuzzy box signed distance
// Fixed-point format, register indexes, internal widths and axis pairing.
// ----------------------------------------------------------------------------
package fbsd_pkg;

    // Fraction bits of the signed fixed-point format (Q11.20 by default)
    localparam int FRAC_BITS = 20;

    // Fuzzy band is 1/128, i.e. 2^(FRAC_BITS-7)
    localparam int EPS_SHIFT = 7;

    localparam int COORD_W = 32;              // point and centre coordinates
    localparam int EXT_W   = 31;              // half_length / radius
    localparam int REL_W   = COORD_W + 1;     // p - c
    localparam int DIST_W  = COORD_W + 2;     // |p - c| - ext
    localparam int DIFF_W  = DIST_W + 1;      // difference of two distances
    localparam int GAP_W   = FRAC_BITS - EPS_SHIFT + 1;
    localparam int SQ_W    = 2 * GAP_W;
    localparam int ADD_W   = SQ_W - FRAC_BITS;
    localparam int AXES    = 3;
    localparam int PAIRS   = 3;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    localparam logic [GAP_W-1:0]  NEAR_BAND = GAP_W'(64'd1 << (FRAC_BITS - EPS_SHIFT));
    localparam logic [EXT_W-1:0]  UNIT_EXT  = EXT_W'(64'd1 << FRAC_BITS);

    typedef logic signed [REL_W-1:0]  t_rel;
    typedef logic signed [DIST_W-1:0] t_dist;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic [EXT_W-1:0]         t_ext;
    typedef logic [GAP_W-1:0]         t_gap;
    typedef logic [ADD_W-1:0]         t_add;

    typedef enum logic [CFG_AW-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_CENTER_Z    = 3'd2,
        CFG_HALF_LENGTH = 3'd3,
        CFG_RADIUS      = 3'd4,
        CFG_LONG_AXIS   = 3'd5
    } t_cfg_reg;

    // Axis pairs xy, xz, yz
    localparam int PAIR_A [PAIRS] = '{0, 0, 1};
    localparam int PAIR_B [PAIRS] = '{1, 2, 2};

endpackage

>>> hdl/fuzzy_box_signed_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_box_signed_distance: streaming signed distance to an axis-aligned box
// One query point per transaction in, one saturated Q11.20 distance out.
// ----------------------------------------------------------------------------
// Throughput: one point per cycle while the output takes results; seven pipeline
//   registers carry a valid bit each, and a stalled output only holds stages that
//   are full (bubbles close).
// Reset: synchronous, active low; clears valid bits and sets the registers to
//   centre 0, half_length = radius = 1.0, long axis x.
// ----------------------------------------------------------------------------
module fuzzy_box_signed_distance (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_wr_en,
    input  logic [fbsd_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [fbsd_pkg::CFG_DW-1:0] i_cfg_wdata,
    // Point stream in
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [95:0]                 i_s_tdata,  // point_x, point_y, point_z
    // Distance stream out
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [31:0]                 o_m_tdata   // distance
);

    localparam int STAGES = 7;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [fbsd_pkg::COORD_W-1:0] r_center [fbsd_pkg::AXES];
    fbsd_pkg::t_ext                      r_half_length;
    fbsd_pkg::t_ext                      r_radius;
    logic [1:0]                          r_long_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0]   <= '0;
            r_center[1]   <= '0;
            r_center[2]   <= '0;
            r_half_length <= fbsd_pkg::UNIT_EXT;
            r_radius      <= fbsd_pkg::UNIT_EXT;
            r_long_axis   <= 2'd0;
        end else if (i_cfg_wr_en) begin
            case (fbsd_pkg::t_cfg_reg'(i_cfg_addr))
                fbsd_pkg::CFG_CENTER_X:    r_center[0]   <= i_cfg_wdata;
                fbsd_pkg::CFG_CENTER_Y:    r_center[1]   <= i_cfg_wdata;
                fbsd_pkg::CFG_CENTER_Z:    r_center[2]   <= i_cfg_wdata;
                fbsd_pkg::CFG_HALF_LENGTH: r_half_length <= i_cfg_wdata[fbsd_pkg::EXT_W-1:0];
                fbsd_pkg::CFG_RADIUS:      r_radius      <= i_cfg_wdata[fbsd_pkg::EXT_W-1:0];
                fbsd_pkg::CFG_LONG_AXIS:   r_long_axis   <= i_cfg_wdata[1:0];
                default: ; // indexes beyond the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or when the
    // stage after it loads too. The last stage looks at the output side.
    // ------------------------------------------------------------------
    logic [STAGES:1] r_vld;
    logic [STAGES:1] w_en;

    always_comb begin
        w_en[STAGES] = !r_vld[STAGES] || i_m_tready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_tready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offset from the centre and pick the extent of each axis
    // ------------------------------------------------------------------
    fbsd_pkg::t_rel r_s1_rel [fbsd_pkg::AXES];
    fbsd_pkg::t_ext r_s1_ext [fbsd_pkg::AXES];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int a = 0; a < fbsd_pkg::AXES; a++) begin
                r_s1_rel[a] <= fbsd_pkg::t_rel'(
                                   $signed(i_s_tdata[a*fbsd_pkg::COORD_W +: fbsd_pkg::COORD_W]))
                             - fbsd_pkg::t_rel'(r_center[a]);
                // Long axis three selects none: all axes use radius
                r_s1_ext[a] <= (r_long_axis == 2'(a)) ? r_half_length : r_radius;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-axis distance |p - c| - ext
    // ------------------------------------------------------------------
    fbsd_pkg::t_dist r_s2_d [fbsd_pkg::AXES];
    logic [fbsd_pkg::REL_W-1:0] w_s2_mag [fbsd_pkg::AXES];

    always_comb begin
        for (int a = 0; a < fbsd_pkg::AXES; a++) begin
            w_s2_mag[a] = r_s1_rel[a][fbsd_pkg::REL_W-1] ? (~r_s1_rel[a] + 1'b1) : r_s1_rel[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int a = 0; a < fbsd_pkg::AXES; a++) begin
                r_s2_d[a] <= $signed({1'b0, w_s2_mag[a]})
                           - $signed({3'b000, r_s1_ext[a]});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pairwise difference and plain maximum
    // ------------------------------------------------------------------
    fbsd_pkg::t_diff r_s3_diff [fbsd_pkg::PAIRS];
    fbsd_pkg::t_dist r_s3_big  [fbsd_pkg::PAIRS];

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int q = 0; q < fbsd_pkg::PAIRS; q++) begin
                r_s3_diff[q] <= fbsd_pkg::t_diff'(r_s2_d[fbsd_pkg::PAIR_A[q]])
                              - fbsd_pkg::t_diff'(r_s2_d[fbsd_pkg::PAIR_B[q]]);
                r_s3_big[q]  <= (r_s2_d[fbsd_pkg::PAIR_A[q]] > r_s2_d[fbsd_pkg::PAIR_B[q]])
                              ? r_s2_d[fbsd_pkg::PAIR_A[q]] : r_s2_d[fbsd_pkg::PAIR_B[q]];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: distance below the fuzzy band edge; zero outside the band
    // (a difference of exactly the band width also gives zero)
    // ------------------------------------------------------------------
    fbsd_pkg::t_dist r_s4_big [fbsd_pkg::PAIRS];
    fbsd_pkg::t_gap  r_s4_gap [fbsd_pkg::PAIRS];
    logic [fbsd_pkg::DIFF_W-1:0] w_s4_abs [fbsd_pkg::PAIRS];

    always_comb begin
        for (int q = 0; q < fbsd_pkg::PAIRS; q++) begin
            w_s4_abs[q] = r_s3_diff[q][fbsd_pkg::DIFF_W-1] ? (~r_s3_diff[q] + 1'b1)
                                                          : r_s3_diff[q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int q = 0; q < fbsd_pkg::PAIRS; q++) begin
                r_s4_big[q] <= r_s3_big[q];
                if (w_s4_abs[q] <= fbsd_pkg::DIFF_W'(fbsd_pkg::NEAR_BAND)) begin
                    r_s4_gap[q] <= fbsd_pkg::NEAR_BAND - w_s4_abs[q][fbsd_pkg::GAP_W-1:0];
                end else begin
                    r_s4_gap[q] <= '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: square the gap and drop the fraction bits (floor)
    // ------------------------------------------------------------------
    fbsd_pkg::t_dist r_s5_big [fbsd_pkg::PAIRS];
    fbsd_pkg::t_add  r_s5_add [fbsd_pkg::PAIRS];
    logic [fbsd_pkg::SQ_W-1:0] w_s5_sq [fbsd_pkg::PAIRS];

    always_comb begin
        for (int q = 0; q < fbsd_pkg::PAIRS; q++) begin
            w_s5_sq[q] = fbsd_pkg::SQ_W'(r_s4_gap[q]) * fbsd_pkg::SQ_W'(r_s4_gap[q]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int q = 0; q < fbsd_pkg::PAIRS; q++) begin
                r_s5_big[q] <= r_s4_big[q];
                r_s5_add[q] <= w_s5_sq[q][fbsd_pkg::SQ_W-1:fbsd_pkg::FRAC_BITS];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: fuzzy maximum of each pair
    // ------------------------------------------------------------------
    fbsd_pkg::t_diff r_s6_val [fbsd_pkg::PAIRS];

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int q = 0; q < fbsd_pkg::PAIRS; q++) begin
                r_s6_val[q] <= fbsd_pkg::t_diff'(r_s5_big[q])
                             + $signed({{(fbsd_pkg::DIFF_W - fbsd_pkg::ADD_W){1'b0}},
                                        r_s5_add[q]});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: largest of the three pairs, saturate to 32 bits
    // ------------------------------------------------------------------
    localparam fbsd_pkg::t_diff SAT_HI = fbsd_pkg::DIFF_W'(64'sd2147483647);
    localparam fbsd_pkg::t_diff SAT_LO = fbsd_pkg::DIFF_W'(-64'sd2147483648);

    logic [31:0]     r_s7_out;
    fbsd_pkg::t_diff w_s7_m01;
    fbsd_pkg::t_diff w_s7_best;

    always_comb begin
        w_s7_m01  = (r_s6_val[0] > r_s6_val[1]) ? r_s6_val[0] : r_s6_val[1];
        w_s7_best = (r_s6_val[2] > w_s7_m01) ? r_s6_val[2] : w_s7_m01;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            if (w_s7_best > SAT_HI) begin
                r_s7_out <= SAT_HI[31:0];
            end else if (w_s7_best < SAT_LO) begin
                r_s7_out <= SAT_LO[31:0];
            end else begin
                r_s7_out <= w_s7_best[31:0];
            end
        end
    end

    assign o_m_tvalid = r_vld[STAGES];
    assign o_m_tdata  = r_s7_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input held off only when every stage is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_vld))
        else $error("input stalled with a free pipeline stage");

    // A full stage 6 moving on lands in the output stage
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[6] && w_en[7]) |=> o_m_tvalid)
        else $error("item lost between stage 6 and output");

    // Gap never exceeds the band width
    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r_s4_gap[0] <= fbsd_pkg::NEAR_BAND && r_s4_gap[1] <= fbsd_pkg::NEAR_BAND
                      && r_s4_gap[2] <= fbsd_pkg::NEAR_BAND))
        else $error("fuzzy gap beyond band width");

    // An accepted transaction reaches stage 1 on the next edge
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[1])
        else $error("accepted transaction not captured");

endmodule

>>> tb/sv/fuzzy_box_signed_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_box_signed_distance_tb: self-checking bench for the box distance
// Streams query points through the block under several box settings. Each
// point is predicted in the bench and compared with the distance that comes
// out. Input bursts and output stalls are random.
// ----------------------------------------------------------------------------
module fuzzy_box_signed_distance_tb;

    import fbsd_pkg::*;

    localparam int     CLK_HALF    = 2;
    localparam int     RESET_TICKS = 12;
    localparam int     PIPE_DEPTH  = 7;          // pipeline stages, input to output
    localparam int     PHASES      = 8;
    localparam int     RAND_ITEMS  = 235;        // random points per setting
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint BAND        = longint'(1) << (FRAC_BITS - EPS_SHIFT);
    localparam longint ONE         = longint'(1) << FRAC_BITS;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own copy of the box registers, predicts the
    // distance for every accepted point and checks results in order.
    // ------------------------------------------------------------------------
    class distance_scoreboard;
        logic signed [31:0] centre [3];
        logic [EXT_W-1:0]   half_len;
        logic [EXT_W-1:0]   rad;
        logic [1:0]         long_ax;
        logic signed [31:0] distance_q [$];
        int                 errors;

        function new();
            centre   = '{0, 0, 0};
            half_len = EXT_W'(ONE);
            rad      = EXT_W'(ONE);
            long_ax  = 2'd0;
            errors   = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_CENTER_X:    centre[0] = val;
                CFG_CENTER_Y:    centre[1] = val;
                CFG_CENTER_Z:    centre[2] = val;
                CFG_HALF_LENGTH: half_len  = val[EXT_W-1:0];
                CFG_RADIUS:      rad       = val[EXT_W-1:0];
                CFG_LONG_AXIS:   long_ax   = val[1:0];
                default: ;
            endcase
        endfunction

        function longint axis_extent(int axis);
            return (axis == int'(long_ax)) ? longint'(half_len) : longint'(rad);
        endfunction

        // Plain maximum, raised by the squared shortfall when within the band
        function longint near_larger(longint a, longint b);
            longint diff;
            longint big;
            longint gap;
            diff = (a > b) ? a - b : b - a;
            big  = (a > b) ? a : b;
            if (diff > BAND)
                return big;
            gap = BAND - diff;
            return big + ((gap * gap) >>> FRAC_BITS);
        endfunction

        function logic signed [31:0] box_distance(logic [95:0] pt);
            longint rel;
            longint axis_d [3];
            longint best;
            longint pair;
            for (int i = 0; i < 3; i++) begin
                rel = longint'($signed(pt[32*i +: 32])) - longint'(centre[i]);
                if (rel < 0)
                    rel = -rel;
                axis_d[i] = rel - axis_extent(i);
            end
            best = near_larger(axis_d[0], axis_d[1]);
            pair = near_larger(axis_d[0], axis_d[2]);
            if (pair > best)
                best = pair;
            pair = near_larger(axis_d[1], axis_d[2]);
            if (pair > best)
                best = pair;
            if (best > longint'(32'sh7FFF_FFFF))
                best = longint'(32'sh7FFF_FFFF);
            if (best < -longint'(64'h8000_0000))
                best = -longint'(64'h8000_0000);
            return best[31:0];
        endfunction

        function void note_point(logic [95:0] pt);
            distance_q.push_back(box_distance(pt));
        endfunction

        function void check_distance(logic signed [31:0] got);
            logic signed [31:0] want;
            if (distance_q.size() == 0) begin
                errors++;
                $display("%0t distance: expected none, actual %0d", $time, got);
                return;
            end
            want = distance_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t distance: expected %0d, actual %0d", $time, want, got);
            end
        endfunction

        function int pending();
            return distance_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]     cfg_addr  = '0;
    logic [CFG_DW-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [95:0]           s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [31:0]           m_tdata;

    distance_scoreboard    sb = new();
    longint                cycles = 0;
    int                    burst_left = 0;
    int                    stall_tick = 0;
    int                    stall_mode = 0;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    fuzzy_box_signed_distance DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),     // point_x, point_y, point_z
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)      // distance
    );

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge. Register writes and accepted points
    // go to the scoreboard; every output transaction is checked.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n) begin
            if (cfg_wr_en)
                sb.write_reg(t_cfg_reg'(cfg_addr), cfg_wdata);
            if (s_tvalid && s_tready)
                sb.note_point(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_distance(m_tdata);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t run timed out with %0d distances outstanding",
                     $time, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure: switch at random between always ready, coin-toss,
    // mostly stalled and a fixed duty pattern.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 256 == 255)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_tick % 4 == 0);
            default: m_tready <= (stall_tick % 16 < 10);
        endcase
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic logic [95:0] pack_point(int x, int y, int z);
        return {z, y, x};
    endfunction

    task automatic idle_input(int ticks);
        repeat (ticks) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    // Present one point and hold it until the block takes it; insert a random
    // gap whenever the current burst runs out.
    task automatic send_point(logic [95:0] pt);
        if (burst_left == 0) begin
            idle_input($urandom_range(0, 1) ? 0 : $urandom_range(1, 10));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= pt;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid, wait for every distance to come back, then let the pipe
    // settle so that a register write cannot land on a point in flight.
    task automatic drain_pipe();
        idle_input(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    task automatic write_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] hl, logic [31:0] rd, logic [31:0] ax);
        logic [31:0]  vals [6];
        t_cfg_reg     regs [6];
        vals = '{cx, cy, cz, hl, rd, ax};
        regs = '{CFG_CENTER_X, CFG_CENTER_Y, CFG_CENTER_Z,
                 CFG_HALF_LENGTH, CFG_RADIUS, CFG_LONG_AXIS};
        for (int i = 0; i < 6; i++) begin
            @(negedge clk);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Box settings per phase: reset values first, then both extremes, a cube
    // with no long axis, then random boxes.
    task automatic configure_phase(int ph);
        logic [31:0] span;
        span = (ph == PHASES - 1) ? 32'hFFFF_FFFF : 32'h01FF_FFFF;
        case (ph)
            1: write_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'd0, 32'd1);
            2: write_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'd0, 32'h7FFF_FFFF, 32'd2);
            3: write_box(32'd0, 32'd0, 32'd0, 32'(3 * ONE / 2), 32'(3 * ONE / 2), 32'd3);
            default: write_box($urandom() & span ^ (span >> 1) ^ (span >> 1) & $urandom(),
                               $urandom_range(0, span) - (span >> 1),
                               $urandom_range(0, span) - (span >> 1),
                               $urandom_range(0, 32'(8 * ONE)),
                               $urandom_range(0, 32'(8 * ONE)),
                               $urandom_range(0, 3));
        endcase
    endtask

    task automatic run_directed(int ph);
        int u;
        int e;
        u = int'(ONE);
        e = int'(BAND);
        case (ph)
            0: begin
                // all three axes tie inside the box: full add-on
                send_point(pack_point(0, 0, 0));
                send_point(pack_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
                send_point(pack_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
                send_point(pack_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0));
                send_point(pack_point(32'sh8000_0000, 0, 32'sh7FFF_FFFF));
                // difference exactly on the band edge, then just outside it
                send_point(pack_point(u + e, u, 0));
                send_point(pack_point(u + e + 1, u, 0));
                send_point(pack_point(u + 100, -(u + 100), 0));
                send_point(pack_point(3 * u, 3 * u + 5, -3 * u - 7));
                send_point(pack_point(u, 0, 0));
                send_point(pack_point(-1, 1, 32'sh8000_0001));
                send_point(pack_point(2 * u, -2 * u - e, u / 2));
                send_point(pack_point(0, u + e / 2, u + e / 2));
                send_point(pack_point(5 * u, 0, 5 * u - 3));
            end
            1: begin
                // far corner saturates; on the centre the ties lift above zero
                send_point(pack_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
                send_point(pack_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
            end
            3: begin
                send_point(pack_point(0, 0, 0));
                send_point(pack_point(3 * u / 2, 3 * u / 2, 3 * u / 2));
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Random points
    // ------------------------------------------------------------------------
    function automatic longint band_offset();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return BAND;
            2:       return -BAND;
            3:       return BAND + 1;
            default: return longint'($urandom_range(0, 32'(2 * BAND))) - BAND;
        endcase
    endfunction

    // Coordinate whose axis distance lands on the target unless it is below -ext
    function automatic logic [31:0] coord_for(int axis, longint target);
        longint ext;
        longint mag;
        longint v;
        ext = sb.axis_extent(axis);
        mag = target + ext;
        if (mag < 0)
            mag = longint'($urandom_range(0, 32'(ext)));
        v = longint'(sb.centre[axis]) + ($urandom_range(0, 1) ? mag : -mag);
        return v[31:0];
    endfunction

    function automatic logic [31:0] edge_coord();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Mostly points whose axis distances crowd together so the fuzzy band
    // is hit often; the rest are full-range noise and boundary values.
    function automatic logic [95:0] random_point();
        logic [95:0] pt;
        longint      base;
        int          pick;
        pick = $urandom_range(0, 99);
        base = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
        for (int i = 0; i < 3; i++) begin
            if (pick < 60)
                pt[32*i +: 32] = ($urandom_range(0, 9) < 7)
                    ? coord_for(i, base + band_offset())
                    : coord_for(i, longint'($urandom_range(0, 1 << 24)) - (1 << 23));
            else if (pick < 85)
                pt[32*i +: 32] = $urandom();
            else
                pt[32*i +: 32] = edge_coord();
        end
        return pt;
    endfunction

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_TICKS) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0)
                configure_phase(ph);
            run_directed(ph);
            for (int n = 0; n < RAND_ITEMS; n++)
                send_point(random_point());
            drain_pipe();
        end

        repeat (4 * PIPE_DEPTH) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
